// ===== rtl/bmul_pkg.sv =====
// Shared widths and defaults for the radix-2 Booth multiplier.
package bmul_pkg;
  localparam int WIDTH_DEFAULT = 16;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 32;

  typedef struct packed {
    logic valid;
  } bmul_ctrl_t;
endpackage

// ===== rtl/booth_radix2_signed_multiplier_top.sv =====
// A word accepted on start appears on product with done after the last cell.
// Throughput: one word per cycle; a chain of WIDTH Booth cells, one step per cell.
// busy is high only during reset; otherwise a new word is taken every cycle.
// The receiver cannot stall: each product shows for exactly one cycle.
// Reset (rst, synchronous, active high) empties the chain; no word is lost after it.
// Top level of the radix-2 Booth signed multiplier.
module booth_radix2_signed_multiplier_top #(
  parameter int WIDTH = bmul_pkg::WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [bmul_pkg::IN_W-1:0]  multiplicand,
  input  logic signed [bmul_pkg::IN_W-1:0]  multiplier,
  output logic                          done,
  output logic signed [bmul_pkg::OUT_W-1:0] product
);
  import bmul_pkg::*;

  logic [WIDTH-1:0] mc_w;
  logic [WIDTH-1:0] mp_w;

  bmul_ctrl_t       ctrl [WIDTH+1];
  logic [WIDTH:0]   acc  [WIDTH+1];
  logic [WIDTH-1:0] q    [WIDTH+1];
  logic             bth  [WIDTH+1];
  logic [WIDTH:0]   pm   [WIDTH+1];
  logic [2*WIDTH-1:0] full;

  assign busy = rst;

  generate
    if (WIDTH <= IN_W) begin : g_narrow
      assign mc_w = multiplicand[WIDTH-1:0];
      assign mp_w = multiplier[WIDTH-1:0];
    end else begin : g_wide
      assign mc_w = {{(WIDTH-IN_W){1'b0}}, multiplicand};
      assign mp_w = {{(WIDTH-IN_W){1'b0}}, multiplier};
    end
  endgenerate

  assign ctrl[0].valid = start & ~busy;
  assign acc[0]        = '0;
  assign q[0]          = mp_w;
  assign bth[0]        = 1'b0;
  assign pm[0]         = {mc_w[WIDTH-1], mc_w};

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    bmul_cell #(.WIDTH(WIDTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl_in  (ctrl[i]),
      .acc_in   (acc[i]),
      .q_in     (q[i]),
      .booth_in (bth[i]),
      .pm_in    (pm[i]),
      .ctrl_out (ctrl[i+1]),
      .acc_out  (acc[i+1]),
      .q_out    (q[i+1]),
      .booth_out(bth[i+1]),
      .pm_out   (pm[i+1])
    );
  end

  assign full = {acc[WIDTH][WIDTH-1:0], q[WIDTH]};
  assign done = ctrl[WIDTH].valid;

  generate
    if (2*WIDTH >= OUT_W) begin : g_pwide
      assign product = full[OUT_W-1:0];
    end else begin : g_pnarrow
      assign product = {{(OUT_W-2*WIDTH){1'b0}}, full};
    end
  endgenerate
endmodule

// ===== rtl/bmul_cell.sv =====
// One Booth step: add plus or minus the multiplicand, or nothing, then shift right by one.
module bmul_cell #(
  parameter int WIDTH = bmul_pkg::WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  bmul_pkg::bmul_ctrl_t ctrl_in,
  input  logic [WIDTH:0]      acc_in,
  input  logic [WIDTH-1:0]    q_in,
  input  logic                booth_in,
  input  logic [WIDTH:0]      pm_in,
  output bmul_pkg::bmul_ctrl_t ctrl_out,
  output logic [WIDTH:0]      acc_out,
  output logic [WIDTH-1:0]    q_out,
  output logic                booth_out,
  output logic [WIDTH:0]      pm_out
);
  import bmul_pkg::*;

  logic           add_en;
  logic           sub;
  logic [WIDTH:0] addend;
  logic [WIDTH:0] sum;

  assign sub    = q_in[0] & ~booth_in;
  assign add_en = q_in[0] ^ booth_in;
  assign addend = add_en ? (pm_in ^ {(WIDTH+1){sub}}) : '0;
  assign sum    = acc_in + addend + {{WIDTH{1'b0}}, (add_en & sub)};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    acc_out   <= {sum[WIDTH], sum[WIDTH:1]};
    q_out     <= {sum[0], q_in[WIDTH-1:1]};
    booth_out <= q_in[0];
    pm_out    <= pm_in;
  end
endmodule

// ===== rtl/bmul_checker.sv =====
// Port-level checks for the Booth multiplier, bound to the top level.
module bmul_checker #(
  parameter int WIDTH = bmul_pkg::WIDTH_DEFAULT
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic signed [bmul_pkg::IN_W-1:0]  multiplicand,
  input logic signed [bmul_pkg::IN_W-1:0]  multiplier,
  input logic                          done,
  input logic signed [bmul_pkg::OUT_W-1:0] product
);
  import bmul_pkg::*;

  logic signed [OUT_W-1:0] ref_prod;
  assign ref_prod = OUT_W'(multiplicand) * OUT_W'(multiplier);

  a_busy_only_in_reset: assert property (@(posedge clk) busy == rst)
    else $error("busy outside reset");

  a_word_returns: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##WIDTH done)
    else $error("accepted word not returned");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, WIDTH))
    else $error("done without accepted word");

  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("done right after reset");

  a_product: assert property (@(posedge clk) disable iff (rst)
    (done && WIDTH == IN_W) |-> product == $past(ref_prod, WIDTH))
    else $error("wrong product");
endmodule

bind booth_radix2_signed_multiplier_top bmul_checker #(.WIDTH(WIDTH)) u_bmul_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .multiplicand(multiplicand),
  .multiplier  (multiplier),
  .done        (done),
  .product     (product)
);
